// ===== hdl/nfua_pkg.sv =====
// ---------------------------------------------------------------------------
// nfua_pkg
// Shared sizes and codes for the next-fit unit allocator.
// ---------------------------------------------------------------------------
package nfua_pkg;

    localparam int MEM_UNITS = 256;
    localparam int ADDR_W    = $clog2(MEM_UNITS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int WIDE_W    = 16;

    localparam int SIZE_W    = 9;
    localparam int START_W   = 8;
    localparam int FREE_W    = 9;
    localparam int RUNS_W    = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ===== hdl/nfua_ram.sv =====
// ---------------------------------------------------------------------------
// nfua_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module nfua_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/next_fit_unit_allocator_core.sv =====
// ---------------------------------------------------------------------------
// next_fit_unit_allocator_core
// Next-fit allocator over a one-bit-per-unit busy map held in RAM.
// ---------------------------------------------------------------------------
// After reset the block clears the busy map and holds o_stall high. One
// word is handled at a time. An allocate scans the map one unit per cycle
// from the stored scan position, then writes its run one unit per cycle; a
// free writes its clipped run the same way. Every operation ends with a
// sweep of the whole map that counts free runs and a step that loads the
// result registers, which waits while an earlier result is held by i_stall.
module next_fit_unit_allocator_core
    import nfua_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [SIZE_W-1:0]  i_block_size,
    input  logic [START_W-1:0] i_block_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_success,
    output logic [START_W-1:0] o_granted_start,
    output logic [FREE_W-1:0]  o_free_units,
    output logic [RUNS_W-1:0]  o_free_run_count
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_CNT   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(MEM_UNITS - 1);
    localparam logic [CNT_W-1:0]  UNITS_C = CNT_W'(MEM_UNITS);

    logic [2:0]        r_state;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_scan, r_pos, r_wa, r_grant;
    logic [CNT_W-1:0]  r_run, r_steps, r_left, r_used, r_ci, r_runs;
    logic              r_wval, r_ok, r_cdv, r_prevb;

    logic               r_ovalid, r_osucc;
    logic [START_W-1:0] r_ogrant;
    logic [FREE_W-1:0]  r_ofree;
    logic [RUNS_W-1:0]  r_oruns;

    logic              ram_we, ram_rd, accept, hit;
    logic [ADDR_W-1:0] ram_wa, ram_ra, pos_next;
    logic [CNT_W-1:0]  run_n;
    logic [WIDE_W-1:0] sum_w, rem_w, left_w;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign pos_next = (r_pos == LAST_A) ? '0 : r_pos + 1'b1;
    assign run_n    = ram_rd ? '0 : ((r_pos == '0) ? CNT_W'(1) : r_run + 1'b1);
    assign hit      = (WIDE_W'(run_n) == WIDE_W'(r_size));

    // free range clipped at the end of memory
    assign rem_w  = (WIDE_W'(i_block_start) >= WIDE_W'(MEM_UNITS)) ? '0
                  : WIDE_W'(MEM_UNITS) - WIDE_W'(i_block_start);
    assign left_w = (WIDE_W'(i_block_size) < rem_w) ? WIDE_W'(i_block_size) : rem_w;
    assign sum_w  = WIDE_W'(r_used) + WIDE_W'(r_size);

    always_comb begin
        ram_we = (r_state == S_CLR) || (r_state == S_WRITE);
        ram_wa = r_wa;
        unique case (r_state)
            S_SCAN:  ram_ra = pos_next;
            S_CNT:   ram_ra = r_ci[ADDR_W-1:0];
            default: ram_ra = r_scan;
        endcase
    end

    nfua_ram #(.WIDTH(1), .DEPTH(MEM_UNITS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (r_wval),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_wa     <= '0;
            r_wval   <= 1'b0;
            r_scan   <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // in S_OUT the result register is handled below
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_wa <= r_wa + 1'b1;
                    if (r_wa == LAST_A) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_size  <= i_block_size;
                        r_grant <= '0;
                        r_ci    <= '0;
                        r_cdv   <= 1'b0;
                        r_prevb <= 1'b1;
                        r_runs  <= '0;
                        if (i_operation == OP_ALLOC) begin
                            r_ok <= 1'b0;
                            if (i_block_size == '0) begin
                                r_state <= S_CNT;
                            end else begin
                                r_pos   <= r_scan;
                                r_run   <= '0;
                                r_steps <= '0;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_ok   <= 1'b1;
                            r_used <= (WIDE_W'(r_used) > WIDE_W'(i_block_size))
                                    ? r_used - CNT_W'(i_block_size) : '0;
                            r_wa   <= i_block_start[ADDR_W-1:0];
                            r_wval <= 1'b0;
                            r_left <= left_w[CNT_W-1:0];
                            r_state <= (left_w == '0) ? S_CNT : S_WRITE;
                        end
                    end
                end
                S_SCAN: begin
                    r_run <= run_n;
                    if (hit) begin
                        r_scan  <= r_pos;
                        r_ok    <= 1'b1;
                        r_grant <= r_pos + 1'b1 - r_size[ADDR_W-1:0];
                        r_wa    <= r_pos + 1'b1 - r_size[ADDR_W-1:0];
                        r_left  <= CNT_W'(r_size);
                        r_wval  <= 1'b1;
                        r_used  <= (sum_w > WIDE_W'(MEM_UNITS)) ? UNITS_C
                                 : sum_w[CNT_W-1:0];
                        r_state <= S_WRITE;
                    end else if (r_steps == CNT_W'(MEM_UNITS - 1)) begin
                        r_state <= S_CNT;
                    end else begin
                        r_pos   <= pos_next;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_wa   <= r_wa + 1'b1;
                    r_left <= r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    if (r_cdv) begin
                        if (!ram_rd && r_prevb) begin
                            r_runs <= r_runs + 1'b1;
                        end
                        r_prevb <= ram_rd;
                    end
                    if (r_ci < UNITS_C) begin
                        r_ci <= r_ci + 1'b1;
                    end
                    r_cdv <= (r_ci < UNITS_C);
                    if (r_cdv && r_ci == UNITS_C) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_osucc  <= r_ok;
                        r_ogrant <= START_W'(r_grant);
                        r_ofree  <= FREE_W'(UNITS_C - r_used);
                        r_oruns  <= RUNS_W'(r_runs);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_success        = r_osucc;
    assign o_granted_start  = r_ogrant;
    assign o_free_units     = r_ofree;
    assign o_free_run_count = r_oruns;

endmodule

// ===== hdl/nfua_checker.sv =====
// ---------------------------------------------------------------------------
// nfua_checker
// Port-level checks on the next-fit unit allocator.
// ---------------------------------------------------------------------------
module nfua_checker
    import nfua_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_success,
    input logic [START_W-1:0] o_granted_start,
    input logic [FREE_W-1:0]  o_free_units
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_granted_start)
                               && $stable(o_free_units))
        else $error("result word changed under stall");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_success |-> o_granted_start == '0)
        else $error("failed allocate reports a start");

    a_free_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_units <= FREE_W'(MEM_UNITS))
        else $error("free units out of range");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while a word is in progress");

endmodule

bind next_fit_unit_allocator_core nfua_checker u_nfua_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_success       (o_success),
    .o_granted_start (o_granted_start),
    .o_free_units    (o_free_units)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives allocate and free words into the next-fit allocator, predicts each
// result from a private model of the busy map and checks every field of it.
// ---------------------------------------------------------------------------
module tb;
    import nfua_pkg::*;

    // Private model of the allocator plus a queue of expected results.
    class alloc_scoreboard;
        bit              busy_map [MEM_UNITS];
        int unsigned     used_cnt;
        int unsigned     scan_pos;
        logic [START_W+FREE_W+RUNS_W:0] pending [$];
        int              mismatches;

        function new();
            for (int i = 0; i < MEM_UNITS; i++) busy_map[i] = 1'b0;
            used_cnt = 0;
            scan_pos = 0;
            mismatches = 0;
        endfunction

        function int unsigned count_runs();
            int unsigned n;
            n = 0;
            for (int i = 0; i < MEM_UNITS; i++)
                if (!busy_map[i] && (i == 0 || busy_map[i-1])) n++;
            return n;
        endfunction

        function void note_word(logic op, int unsigned size, int unsigned first);
            int unsigned run;
            int unsigned granted;
            int unsigned base;
            bit ok;
            run = 0;
            granted = 0;
            ok = 1'b0;
            if (op == OP_ALLOC) begin
                if (size != 0) begin
                    for (int i = 0; i < MEM_UNITS && !ok; i++) begin
                        // runs never span the wrap to unit 0
                        if (scan_pos == 0) run = 0;
                        if (busy_map[scan_pos]) run = 0;
                        else run++;
                        if (run >= size) begin
                            base = scan_pos + 1 - run;
                            for (int j = 0; j < size; j++) busy_map[base+j] = 1'b1;
                            used_cnt += size;
                            if (used_cnt > MEM_UNITS) used_cnt = MEM_UNITS;
                            granted = base;
                            ok = 1'b1;
                        end else begin
                            scan_pos = (scan_pos + 1) % MEM_UNITS;
                        end
                    end
                end
            end else begin
                for (int j = 0; j < size; j++)
                    if (first + j < MEM_UNITS) busy_map[first+j] = 1'b0;
                used_cnt = (used_cnt > size) ? used_cnt - size : 0;
                ok = 1'b1;
            end
            pending.push_back({ok, granted[START_W-1:0],
                               FREE_W'(MEM_UNITS - used_cnt), RUNS_W'(count_runs())});
        endfunction

        function void check_word(logic ok, logic [START_W-1:0] gs,
                                 logic [FREE_W-1:0] fu, logic [RUNS_W-1:0] rc);
            logic [START_W+FREE_W+RUNS_W:0] want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
                return;
            end
            want = pending.pop_front();
            if (want !== {ok, gs, fu, rc}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp ok=%0d gs=%0d fu=%0d rc=%0d got %0d %0d %0d %0d",
                             want[START_W+FREE_W+RUNS_W],
                             want[FREE_W+RUNS_W +: START_W], want[RUNS_W +: FREE_W],
                             want[RUNS_W-1:0], ok, gs, fu, rc);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_operation;
    logic [SIZE_W-1:0]  i_block_size;
    logic [START_W-1:0] i_block_start;
    logic               o_valid;
    logic               i_stall;
    logic               o_success;
    logic [START_W-1:0] o_granted_start;
    logic [FREE_W-1:0]  o_free_units;
    logic [RUNS_W-1:0]  o_free_run_count;

    alloc_scoreboard sb;

    next_fit_unit_allocator_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_word(logic op, int unsigned size, int unsigned first);
        int gap;
        gap = $urandom_range(0, 8);
        repeat (gap) @(posedge i_clk);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_block_size  <= SIZE_W'(size);
        i_block_start <= START_W'(first);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(op, size, first);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly modest sizes so the map churns between full and empty.
    task automatic send_random();
        int unsigned r;
        int unsigned size;
        r = $urandom_range(0, 99);
        if (r < 5)       size = $urandom_range(0, 511);
        else if (r < 15) size = $urandom_range(0, 256);
        else             size = $urandom_range(1, 24);
        send_word($urandom_range(0, 99) < 55 ? OP_ALLOC : OP_FREE,
                  size, $urandom_range(0, 255));
    endtask

    // Result side: random stall per word, with stall-free stretches.
    initial begin
        int hold;
        i_stall <= 1'b1;
        @(posedge i_rst_n);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_word(o_success, o_granted_start, o_free_units, o_free_run_count);
        end
    end

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_operation   <= OP_ALLOC;
        i_block_size  <= '0;
        i_block_start <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero size, full-map, oversize, wrap, frees past the end
        send_word(OP_ALLOC, 0, 0);
        send_word(OP_ALLOC, 256, 0);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_FREE, 256, 0);
        send_word(OP_ALLOC, 257, 0);
        send_word(OP_ALLOC, 511, 0);
        send_word(OP_ALLOC, 200, 0);
        send_word(OP_ALLOC, 60, 0);
        send_word(OP_ALLOC, 50, 0);
        send_word(OP_FREE, 10, 0);
        send_word(OP_ALLOC, 20, 0);
        send_word(OP_ALLOC, 8, 0);
        send_word(OP_FREE, 20, 250);
        send_word(OP_FREE, 511, 255);
        send_word(OP_FREE, 3, 255);
        send_word(OP_FREE, 0, 128);
        send_word(OP_FREE, 1, 170);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_FREE, 511, 0);
        send_word(OP_FREE, 5, 5);
        send_word(OP_ALLOC, 255, 0);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_ALLOC, 2, 0);

        // hold off until the block has drained
        while (sb.pending.size() != 0) @(posedge i_clk);

        repeat (1100) send_random();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
